// ----- hdl/dnsp_pkg.sv -----
package dnsp_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [7:0]  PTR_MASK        = 8'hC0;
    localparam logic [7:0]  RESP_BIT_MASK   = 8'h80;
    localparam logic [7:0]  RCODE_MASK      = 8'h0F;
    localparam logic [3:0]  FIXED_LAST_IDX  = 4'd9;
    localparam logic [3:0]  RDLEN_HI_IDX    = 4'd8;
    localparam logic [3:0]  ADDR_BYTES      = 4'd4;
    localparam logic [15:0] A_RDLEN         = 16'd4;
    localparam logic [7:0]  A_TYPE_LO       = 8'd1;
    localparam logic [15:0] QSKIP_AFTER_END = 16'd4;
    localparam logic [15:0] QSKIP_AFTER_PTR = 16'd5;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QSKIP  = 4'd2,
        PH_RNAME  = 4'd3,
        PH_RPTR   = 4'd4,
        PH_RFIXED = 4'd5,
        PH_ADDR   = 4'd6,
        PH_RDATA  = 4'd7,
        PH_DONE   = 4'd8
    } t_phase;

    localparam logic [1:0] OUTCOME_NOT_OURS  = 2'd0;
    localparam logic [1:0] OUTCOME_FOUND     = 2'd1;
    localparam logic [1:0] OUTCOME_NO_ANSWER = 2'd2;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [31:0] address;
    } t_result;

endpackage

// ----- hdl/dnsp_in_reg.sv -----
module dnsp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_last
);
    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_last;
    logic       load;

    assign o_stall = r_valid && !i_advance;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data_byte <= i_data_byte;
            r_last      <= i_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data_byte;
    assign o_last      = r_last;
endmodule

// ----- hdl/dnsp_parser.sv -----
module dnsp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last,
    input  logic [15:0]     i_expected_id,
    output dnsp_pkg::t_result o_result
);
    import dnsp_pkg::*;

    logic [POS_W-1:0] r_pos,        n_pos;
    t_phase           r_phase,      n_phase;
    logic             r_header_ok,  n_header_ok;
    logic             r_rcode_zero, n_rcode_zero;
    logic [15:0]      r_answers,    n_answers;
    logic [15:0]      r_skip,       n_skip;
    logic [3:0]       r_idx,        n_idx;
    logic             r_type_ok,    n_type_ok;
    logic [15:0]      r_rdlen,      n_rdlen;
    logic [31:0]      r_addr,       n_addr;
    logic             r_found,      n_found;

    always_comb begin
        logic [7:0]  b;
        logic        name_end;
        logic        name_ptr;
        logic [15:0] dec_skip;
        logic        do_begin;

        b        = i_data_byte;
        name_end = 1'b0;
        name_ptr = 1'b0;
        dec_skip = (r_skip != 16'd0) ? r_skip - 16'd1 : 16'd0;
        do_begin = 1'b0;

        n_pos        = r_pos;
        n_phase      = r_phase;
        n_header_ok  = r_header_ok;
        n_rcode_zero = r_rcode_zero;
        n_answers    = r_answers;
        n_skip       = r_skip;
        n_idx        = r_idx;
        n_type_ok    = r_type_ok;
        n_rdlen      = r_rdlen;
        n_addr       = r_addr;
        n_found      = r_found;

        // shared name byte handling for question and record names
        if (r_skip != 16'd0) begin
            n_skip = dec_skip;
        end else if (b == 8'd0) begin
            name_end = 1'b1;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
            name_ptr = 1'b1;
        end else begin
            n_skip = {8'd0, b};
        end

        if (r_pos < POS_W'(MAX_PACKET_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            unique case (r_phase)
                PH_HEADER: begin
                    n_skip = r_skip;
                    if (r_pos == POS_W'(0)) begin
                        n_header_ok = (b == i_expected_id[15:8]);
                    end else if (r_pos == POS_W'(1)) begin
                        n_header_ok = r_header_ok && (b == i_expected_id[7:0]);
                    end else if (r_pos == POS_W'(2)) begin
                        n_header_ok = r_header_ok && ((b & RESP_BIT_MASK) != 8'd0);
                    end else if (r_pos == POS_W'(3)) begin
                        n_rcode_zero = ((b & RCODE_MASK) == 8'd0);
                    end else if (r_pos == POS_W'(6)) begin
                        n_answers = {b, 8'd0};
                    end else if (r_pos == POS_W'(7)) begin
                        n_answers = r_answers | {8'd0, b};
                    end else if (r_pos == POS_W'(11)) begin
                        n_skip  = 16'd0;
                        n_phase = r_header_ok ? PH_QNAME : PH_DONE;
                    end
                end
                PH_QNAME: begin
                    if (name_end) begin
                        n_skip  = QSKIP_AFTER_END;
                        n_phase = PH_QSKIP;
                    end else if (name_ptr) begin
                        n_skip  = QSKIP_AFTER_PTR;
                        n_phase = PH_QSKIP;
                    end
                end
                PH_QSKIP, PH_RDATA: begin
                    n_skip   = dec_skip;
                    do_begin = (dec_skip == 16'd0);
                end
                PH_RNAME: begin
                    if (name_end) begin
                        n_phase   = PH_RFIXED;
                        n_idx     = 4'd0;
                        n_type_ok = 1'b0;
                        n_rdlen   = 16'd0;
                    end else if (name_ptr) begin
                        n_phase = PH_RPTR;
                    end
                end
                PH_RPTR: begin
                    n_skip    = r_skip;
                    n_phase   = PH_RFIXED;
                    n_idx     = 4'd0;
                    n_type_ok = 1'b0;
                    n_rdlen   = 16'd0;
                end
                PH_RFIXED: begin
                    n_skip = r_skip;
                    if (r_idx == 4'd0) begin
                        n_type_ok = (b == 8'd0);
                    end else if (r_idx == 4'd1) begin
                        n_type_ok = r_type_ok && (b == A_TYPE_LO);
                    end else if (r_idx == RDLEN_HI_IDX) begin
                        n_rdlen = {b, 8'd0};
                    end else if (r_idx == FIXED_LAST_IDX) begin
                        n_rdlen = r_rdlen | {8'd0, b};
                    end
                    if (r_idx >= FIXED_LAST_IDX) begin
                        n_idx = 4'd0;
                        if (n_type_ok && n_rdlen == A_RDLEN) begin
                            n_addr  = 32'd0;
                            n_phase = PH_ADDR;
                        end else if (n_rdlen == 16'd0) begin
                            do_begin = 1'b1;
                        end else begin
                            n_skip  = n_rdlen;
                            n_phase = PH_RDATA;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_ADDR: begin
                    n_skip = r_skip;
                    n_addr = {r_addr[23:0], b};
                    n_idx  = r_idx + 4'd1;
                    if (n_idx >= ADDR_BYTES) begin
                        n_found = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_skip = r_skip;
                end
            endcase

            if (do_begin) begin
                if (r_rcode_zero && r_answers != 16'd0) begin
                    n_answers = r_answers - 16'd1;
                    n_skip    = 16'd0;
                    n_phase   = PH_RNAME;
                end else begin
                    n_phase = PH_DONE;
                end
            end
        end else begin
            n_skip = r_skip;
        end
    end

    always_comb begin
        if (n_phase == PH_HEADER || !n_header_ok) begin
            o_result.outcome = OUTCOME_NOT_OURS;
            o_result.address = 32'd0;
        end else if (n_found) begin
            o_result.outcome = OUTCOME_FOUND;
            o_result.address = n_addr;
        end else begin
            o_result.outcome = OUTCOME_NO_ANSWER;
            o_result.address = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos        <= '0;
            r_phase      <= PH_HEADER;
            r_header_ok  <= 1'b0;
            r_rcode_zero <= 1'b0;
            r_answers    <= 16'd0;
            r_skip       <= 16'd0;
            r_idx        <= 4'd0;
            r_type_ok    <= 1'b0;
            r_rdlen      <= 16'd0;
            r_addr       <= 32'd0;
            r_found      <= 1'b0;
        end else if (i_en) begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_header_ok  <= n_header_ok;
            r_rcode_zero <= n_rcode_zero;
            r_answers    <= n_answers;
            r_skip       <= n_skip;
            r_idx        <= n_idx;
            r_type_ok    <= n_type_ok;
            r_rdlen      <= n_rdlen;
            r_addr       <= n_addr;
            r_found      <= n_found;
        end
    end
endmodule

// ----- hdl/dnsp_out_reg.sv -----
module dnsp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dnsp_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output dnsp_pkg::t_result o_result
);
    import dnsp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

// ----- hdl/dns_response_a_record_parser_top.sv -----
// a response transaction is loaded into the output register when its last byte leaves the input register
// throughput: one byte per cycle; a last byte waits only while the output register is held
// bytes pass an input register, one parse step, then the output register
// reset (i_rst_n low, synchronous) clears the parser, both registers and expected_id
// the parser returns to its reset state after every last byte; expected_id is kept
module dns_response_a_record_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_outcome,
    output logic [31:0] o_address
);
    import dnsp_pkg::*;

    logic [15:0] r_expected_id;
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        byte_last;
    logic        out_free;
    logic        advance;
    t_result     parse_result;
    t_result     out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= 16'd0;
        end else if (i_cfg_wr_en) begin
            r_expected_id <= i_cfg_wr_data;
        end
    end

    assign advance = byte_valid && (!byte_last || out_free);

    dnsp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_advance   (advance),
        .o_valid     (byte_valid),
        .o_data_byte (byte_data),
        .o_last      (byte_last)
    );

    dnsp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_data_byte   (byte_data),
        .i_last        (byte_last),
        .i_expected_id (r_expected_id),
        .o_result      (parse_result)
    );

    dnsp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && byte_last),
        .i_result (parse_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_outcome = out_result.outcome;
    assign o_address = out_result.address;
endmodule
